@@ hdl/rc_packet_to_sbus_frame_macros.svh @@
// ============================================================================
// rc_packet_to_sbus_frame_macros.svh
// Assertion macros used by the SBUS frame serializer module rcsb_frame_tx.
// ============================================================================
`ifndef RC_PACKET_TO_SBUS_FRAME_MACROS_SVH
`define RC_PACKET_TO_SBUS_FRAME_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define RCSB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define RCSB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/rcsb_pkg.sv @@
// ============================================================================
// rcsb_pkg
// Types, constants and the channel packing function of the SBUS encoder.
// ============================================================================
package rcsb_pkg;

    // Frame geometry
    localparam int SBUS_FRAME_BYTES = 25;
    localparam int FRAME_IDX_W      = $clog2(SBUS_FRAME_BYTES);
    localparam int CHAN_BYTES       = 12;
    localparam int BODY_BYTES       = 11;

    // Packet positions
    localparam logic [4:0] POS_LEN       = 5'd0;
    localparam logic [4:0] POS_ID_FIRST  = 5'd1;
    localparam logic [4:0] POS_ID_SECOND = 5'd2;
    localparam logic [4:0] POS_CH_FIRST  = 5'd6;
    localparam logic [4:0] POS_END       = 5'd19;

    // Packet and frame constants
    localparam logic [7:0]  LEN_MARK   = 8'h11;
    localparam logic [7:0]  SYNC_BYTE  = 8'h0F;
    localparam logic [7:0]  LOST_FLAG  = 8'h04;
    localparam logic [15:0] CH_OFFSET  = 16'd1260;

    // Frame byte indexes with fixed content
    localparam logic [FRAME_IDX_W-1:0] IDX_SYNC  = FRAME_IDX_W'(0);
    localparam logic [FRAME_IDX_W-1:0] IDX_FLAGS = FRAME_IDX_W'(23);
    localparam logic [FRAME_IDX_W-1:0] IDX_LAST  = FRAME_IDX_W'(SBUS_FRAME_BYTES - 1);

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_TX_ID_FIRST  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TX_ID_SECOND = 1'b1;

    typedef logic [CHAN_BYTES-1:0][7:0] chan_bytes_t;
    typedef logic [BODY_BYTES-1:0][7:0] frame_body_t;

    // Frame request from the decoder to the transmitter
    typedef struct packed {
        logic        valid;
        logic        lost;
        chan_bytes_t chan;
    } frame_req_t;

    // One channel: 12-bit raw value minus offset, 16-bit wrap
    function automatic logic [15:0] chan_value(input logic [7:0] lo_byte,
                                               input logic [3:0] nib);
        return {4'b0000, nib, lo_byte} - CH_OFFSET;
    endfunction

    // Unpack eight channels and pack them into frame bytes 1..11
    function automatic frame_body_t pack_channels(input chan_bytes_t cb);
        logic [15:0] c [8];
        logic [15:0] t [BODY_BYTES];
        frame_body_t body;
        c[0] = chan_value(cb[0], cb[4][3:0]);
        c[1] = chan_value(cb[1], cb[4][7:4]);
        c[2] = chan_value(cb[2], cb[5][3:0]);
        c[3] = chan_value(cb[3], cb[5][7:4]);
        c[4] = chan_value(cb[6], cb[10][3:0]);
        c[5] = chan_value(cb[7], cb[10][7:4]);
        c[6] = chan_value(cb[8], cb[11][3:0]);
        c[7] = chan_value(cb[9], cb[11][7:4]);
        t[0]  = c[0];
        t[1]  = (c[1] << 3) | (c[0] >> 8);
        t[2]  = (c[1] >> 5) | (c[2] << 6);
        t[3]  = c[2] >> 2;
        t[4]  = (c[2] >> 10) | (c[3] << 1);
        t[5]  = (c[3] >> 7) | (c[4] << 4);
        t[6]  = (c[4] >> 4) | (c[5] << 7);
        t[7]  = c[5] >> 1;
        t[8]  = (c[5] >> 9) | (c[6] << 2);
        t[9]  = (c[6] >> 6) | (c[7] << 5);
        t[10] = c[7] >> 3;
        for (int i = 0; i < BODY_BYTES; i++)
        begin
            body[i] = t[i][7:0];
        end
        return body;
    endfunction

endpackage

@@ hdl/rc_packet_to_sbus_frame.sv @@
// ============================================================================
// rc_packet_to_sbus_frame
// Radio packet bytes in, 25-byte SBUS frames out.
// ============================================================================
// Usage:
//   Input channel (in_valid/in_ready): one transaction per packet byte
//   (kind 0, data_byte, byte_position) or a frame-lost tick (kind 1).
//   Output channel (out_valid/out_ready): one frame byte per transaction,
//   frame_end marks byte 24.
//   Config channel (cfg_valid/cfg_ready, always ready): index 0 sets the
//   first transmitter id byte, index 1 the second.
// Path: the first byte of a frame is offered once the transaction that
//   caused it has been accepted into the input register and loaded into
//   the frame register; a frame still in progress holds it in between.
// Throughput: an item is taken every cycle unless it waits for a frame.
//   A frame is 25 output bytes; an item causing a frame waits in the input
//   register while a frame drains; the next loads as its last byte leaves.
// Reset: transmitter ids and stored channel data read zero, no frame pending.
// Receiver stall: the output byte holds; input backs up once an item needs
//   a frame while one is still in progress.
// ============================================================================
module rc_packet_to_sbus_frame
    import rcsb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 kind,
    input  logic [7:0]           data_byte,
    input  logic [4:0]           byte_position,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           sbus_byte,
    output logic                 frame_end,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data
);

    frame_req_t req;
    logic       req_ready;

    // Configuration writes always complete
    assign cfg_ready = 1'b1;

    rcsb_decode u_decode (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .data_byte     (data_byte),
        .byte_position (byte_position),
        .cfg_write     (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .req           (req),
        .req_ready     (req_ready)
    );

    rcsb_frame_tx u_frame_tx (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .req_ready (req_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sbus_byte (sbus_byte),
        .frame_end (frame_end)
    );

endmodule

@@ hdl/rcsb_decode.sv @@
// ============================================================================
// rcsb_decode
// Input register, packet staging, validity check and frame requests.
// ============================================================================
module rcsb_decode
    import rcsb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // input transactions
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 kind,
    input  logic [7:0]           data_byte,
    input  logic [4:0]           byte_position,
    // configuration writes
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data,
    // frame requests
    output frame_req_t           req,
    input  logic                 req_ready
);

    logic        item_valid_reg;
    logic        kind_reg;
    logic [7:0]  data_reg;
    logic [4:0]  pos_reg;
    logic [7:0]  tx_id_first_reg;
    logic [7:0]  tx_id_second_reg;
    logic        len_ok_reg;
    logic [7:0]  id_first_reg;
    logic [7:0]  id_second_reg;
    chan_bytes_t staged_reg;
    chan_bytes_t last_good_reg;
    logic        is_end;
    logic        packet_ok;
    logic        needs_frame;
    logic        consume;
    logic        take_byte;

    // Packet check on the byte held in the input register
    assign is_end      = !kind_reg && (pos_reg == POS_END);
    assign packet_ok   = len_ok_reg && data_reg[7] &&
                         (id_first_reg == tx_id_first_reg) &&
                         (id_second_reg == tx_id_second_reg);
    assign needs_frame = item_valid_reg && (kind_reg || (is_end && packet_ok));
    assign consume     = item_valid_reg && (!needs_frame || req_ready);
    assign take_byte   = consume && !kind_reg;
    assign in_ready    = !item_valid_reg || consume;

    // Frame request: fresh channels for a good packet, stored ones for a tick
    always_comb
    begin
        req.valid = needs_frame;
        req.lost  = kind_reg;
        req.chan  = kind_reg ? last_good_reg : staged_reg;
    end

    // Input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            item_valid_reg <= in_valid;
        end
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            kind_reg <= kind;
            data_reg <= data_byte;
            pos_reg  <= byte_position;
        end
    end

    // Configuration registers, length mark and last good channel data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_id_first_reg  <= 8'h00;
            tx_id_second_reg <= 8'h00;
            len_ok_reg       <= 1'b0;
            last_good_reg    <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_TX_ID_FIRST:  tx_id_first_reg  <= cfg_data;
                    REG_TX_ID_SECOND: tx_id_second_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (take_byte && (pos_reg == POS_LEN))
            begin
                len_ok_reg <= (data_reg == LEN_MARK);
            end
            if (take_byte && is_end && packet_ok)
            begin
                last_good_reg <= staged_reg;
            end
        end
    end

    // Staged id and channel bytes, undefined until written
    always_ff @(posedge clk)
    begin
        if (take_byte && (pos_reg == POS_ID_FIRST))
        begin
            id_first_reg <= data_reg;
        end
        if (take_byte && (pos_reg == POS_ID_SECOND))
        begin
            id_second_reg <= data_reg;
        end
        for (int i = 0; i < CHAN_BYTES; i++)
        begin
            if (take_byte && (pos_reg == POS_CH_FIRST + 5'(i)))
            begin
                staged_reg[i] <= data_reg;
            end
        end
    end

endmodule

@@ hdl/rcsb_frame_tx.sv @@
// ============================================================================
// rcsb_frame_tx
// Frame register and byte serializer for the 25-byte SBUS frame.
// ============================================================================
`include "rc_packet_to_sbus_frame_macros.svh"

module rcsb_frame_tx
    import rcsb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    // frame requests
    input  frame_req_t req,
    output logic       req_ready,
    // output transactions
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] sbus_byte,
    output logic       frame_end
);

    localparam int BODY_IDX_W = $clog2(BODY_BYTES);

    logic                   busy_reg;
    logic [FRAME_IDX_W-1:0] idx_reg;
    frame_body_t            body_reg;
    logic                   lost_reg;
    logic                   load;
    logic                   last;
    logic                   out_xfer;
    logic [BODY_IDX_W-1:0]  body_idx;

    assign last      = (idx_reg == IDX_LAST);
    assign out_xfer  = busy_reg && out_ready;
    assign req_ready = !busy_reg || (last && out_ready);
    assign load      = req.valid && req_ready;

    // Frame bytes 1..11 map to body entries 0..10
    assign body_idx  = idx_reg[BODY_IDX_W-1:0] - 1'b1;

    // Serializer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (out_xfer)
        begin
            if (last)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    // Packed frame body, captured on load
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            body_reg <= pack_channels(req.chan);
            lost_reg <= req.lost;
        end
    end

    // Byte select
    always_comb
    begin
        case (idx_reg)
            IDX_SYNC:  sbus_byte = SYNC_BYTE;
            IDX_FLAGS: sbus_byte = lost_reg ? LOST_FLAG : 8'h00;
            default:
            begin
                if (idx_reg <= FRAME_IDX_W'(BODY_BYTES))
                begin
                    sbus_byte = body_reg[body_idx];
                end
                else
                begin
                    sbus_byte = 8'h00;
                end
            end
        endcase
    end

    assign out_valid = busy_reg;
    assign frame_end = last;

    // A new frame is taken only when idle or as the last byte leaves
    `RCSB_ASSERT_NOW(a_load_gap, clk, rst_n, load && busy_reg, last && out_ready,
        "frame loaded over a frame in progress")
    // A byte that is not the last advances the index
    `RCSB_ASSERT_NEXT(a_advance, clk, rst_n, out_xfer && !last,
        busy_reg && (idx_reg == $past(idx_reg) + 1'b1), "byte index did not advance")
    // The frame closes after its last byte unless another is loaded
    `RCSB_ASSERT_NEXT(a_close, clk, rst_n, out_xfer && last && !req.valid,
        !busy_reg, "serializer still busy after frame end")

endmodule

@@ verif/sbus_frame_checker.sv @@
`timescale 1ns / 100ps
// ============================================================================
// sbus_frame_checker
// Watches the packet, config and frame channels of the SBUS encoder, keeps
// its own copy of the encoder state, predicts every frame byte and compares
// each output transaction against the oldest predicted byte.
// ============================================================================

// Codes shared by the checker and the testbench top
package sbus_tb_pkg;

    localparam logic KIND_BYTE  = 1'b0;   // radio packet byte
    localparam logic KIND_TICK  = 1'b1;   // frame-lost tick
    localparam int   END_OK_BIT = 7;      // end byte flag that marks a good packet

endpackage

module sbus_frame_checker
    import rcsb_pkg::*;
    import sbus_tb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic                 kind,
    input  logic [7:0]           data_byte,
    input  logic [4:0]           byte_position,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [7:0]           sbus_byte,
    input  logic                 frame_end,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data,
    output int                   mismatch_count,
    output int                   expected_left,
    output int                   frames_seen
);

    // Only the first mismatches are printed, all of them are counted
    localparam int PRINT_CAP = 40;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
        logic [7:0] slot;
    } frame_byte_t;

    frame_byte_t frame_byte_q [$];
    frame_byte_t want;

    // Mirror of the encoder state
    logic [7:0]  id_first_reg;
    logic [7:0]  id_second_reg;
    chan_bytes_t staged_chan;
    logic [7:0]  staged_id [2];
    logic        staged_len_ok;
    chan_bytes_t good_chan;

    initial
    begin
        mismatch_count = 0;
        frames_seen    = 0;
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_CAP)
        begin
            $display("%0t: %s", $time, msg);
        end
        mismatch_count++;
    endtask

    // Build one 25-byte frame from the channel bytes and queue it
    task automatic queue_frame(input chan_bytes_t cb, input logic lost);
        logic [31:0] ch [8];
        logic [31:0] word [SBUS_FRAME_BYTES];
        logic [15:0] raw;
        logic [15:0] wrapped;
        logic [3:0]  nib;
        int          base;
        int          m;
        for (int k = 0; k < 8; k++)
        begin
            // channels 0..3 come from bytes 0..5, channels 4..7 from bytes 6..11
            base = (k / 4) * 6;
            m    = k % 4;
            nib  = (m % 2 == 1) ? cb[base + 4 + m / 2][7:4] : cb[base + 4 + m / 2][3:0];
            raw  = {4'd0, nib, cb[base + m]};
            wrapped = raw - CH_OFFSET;
            ch[k] = {16'd0, wrapped};
        end
        for (int j = 0; j < SBUS_FRAME_BYTES; j++)
        begin
            word[j] = '0;
        end
        word[0]  = {24'd0, SYNC_BYTE};
        word[1]  = ch[0];
        word[2]  = (ch[1] << 3) | (ch[0] >> 8);
        word[3]  = (ch[1] >> 5) | (ch[2] << 6);
        word[4]  = ch[2] >> 2;
        word[5]  = (ch[2] >> 10) | (ch[3] << 1);
        word[6]  = (ch[3] >> 7) | (ch[4] << 4);
        word[7]  = (ch[4] >> 4) | (ch[5] << 7);
        word[8]  = ch[5] >> 1;
        word[9]  = (ch[5] >> 9) | (ch[6] << 2);
        word[10] = (ch[6] >> 6) | (ch[7] << 5);
        word[11] = ch[7] >> 3;
        word[IDX_FLAGS] = lost ? {24'd0, LOST_FLAG} : 32'd0;
        for (int j = 0; j < SBUS_FRAME_BYTES; j++)
        begin
            frame_byte_q.push_back('{value: word[j][7:0],
                                     last:  (j == SBUS_FRAME_BYTES - 1),
                                     slot:  8'(j)});
        end
    endtask

    // Apply one accepted input transaction to the mirrored state
    task automatic predict_item(input logic k, input logic [7:0] d, input logic [4:0] p);
        if (k == KIND_TICK)
        begin
            queue_frame(good_chan, 1'b1);
        end
        else if (p == POS_LEN)
        begin
            staged_len_ok = (d == LEN_MARK);
        end
        else if (p == POS_ID_FIRST)
        begin
            staged_id[0] = d;
        end
        else if (p == POS_ID_SECOND)
        begin
            staged_id[1] = d;
        end
        else if (p >= POS_CH_FIRST && p < POS_CH_FIRST + CHAN_BYTES)
        begin
            staged_chan[p - POS_CH_FIRST] = d;
        end
        else if (p == POS_END)
        begin
            // staged bytes stay, so a repeated end byte is judged again
            if (staged_len_ok && d[END_OK_BIT] &&
                staged_id[0] == id_first_reg && staged_id[1] == id_second_reg)
            begin
                good_chan = staged_chan;
                queue_frame(good_chan, 1'b0);
            end
        end
    endtask

    // Compare one output transaction with the oldest predicted byte
    task automatic check_frame_byte();
        if (frame_byte_q.size() == 0)
        begin
            report_mismatch($sformatf("frame byte 0x%02h (end %0b) with nothing expected",
                                      sbus_byte, frame_end));
        end
        else
        begin
            want = frame_byte_q.pop_front();
            if (sbus_byte !== want.value)
            begin
                report_mismatch($sformatf("frame byte %0d: sbus_byte 0x%02h, expected 0x%02h",
                                          want.slot, sbus_byte, want.value));
            end
            if (frame_end !== want.last)
            begin
                report_mismatch($sformatf("frame byte %0d: frame_end %0b, expected %0b",
                                          want.slot, frame_end, want.last));
            end
            if (want.last)
            begin
                frames_seen++;
            end
        end
    endtask

    // Watch all three channels; output first so a byte never meets its own prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_byte_q.delete();
            id_first_reg  = '0;
            id_second_reg = '0;
            staged_chan   = '0;
            staged_id[0]  = '0;
            staged_id[1]  = '0;
            staged_len_ok = 1'b0;
            good_chan     = '0;
            expected_left <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                check_frame_byte();
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_TX_ID_FIRST:  id_first_reg  = cfg_data;
                    REG_TX_ID_SECOND: id_second_reg = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                predict_item(kind, data_byte, byte_position);
            end
            expected_left <= frame_byte_q.size();
        end
    end

endmodule

@@ verif/rc_packet_to_sbus_frame_tb.sv @@
`timescale 1ns / 100ps
// ============================================================================
// rc_packet_to_sbus_frame_tb
// Drives radio packet bytes and frame-lost ticks into the SBUS encoder:
// a directed sweep of the packet corner cases, then random well-formed,
// broken and noise packets under several transmitter id settings, with
// random sender gaps and receiver stalls. The checker does the comparing.
// ============================================================================
module rc_packet_to_sbus_frame_tb;

    import rcsb_pkg::*;
    import sbus_tb_pkg::*;

    localparam int ITEM_TARGET   = 500;
    localparam int SETTING_SPAN  = 100;
    localparam int SETTLE_CYCLES = 6;
    localparam int DRAIN_CYCLES  = 40;
    localparam int CYCLE_LIMIT   = 500000;

    localparam logic [4:0] POS_SPARE_FIRST = 5'd3;
    localparam logic [4:0] POS_SPARE_LAST  = 5'd18;
    localparam logic [4:0] POS_BEYOND      = 5'd20;
    localparam logic [4:0] POS_TOP         = 5'd31;

    // Channel bytes 6..17 for the directed packet, byte 0 in the low bits
    localparam logic [CHAN_BYTES*8-1:0] EDGE_CHAN = 96'h0F_F0_00_FF_00_FF_F0_0F_FF_00_FF_00;

    typedef enum logic [1:0] {SINK_FREE, SINK_CHOPPY, SINK_SLOW} sink_mode_t;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 in_valid      = 1'b0;
    logic                 in_ready;
    logic                 kind          = KIND_BYTE;
    logic [7:0]           data_byte     = '0;
    logic [4:0]           byte_position = '0;
    logic                 out_valid;
    logic                 out_ready     = 1'b0;
    logic [7:0]           sbus_byte;
    logic                 frame_end;
    logic                 cfg_valid     = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index     = REG_TX_ID_FIRST;
    logic [7:0]           cfg_data      = '0;

    int         mismatch_count;
    int         expected_left;
    int         frames_seen;
    int         cycle_count   = 0;
    int         stall_left    = 0;
    sink_mode_t sink_mode     = SINK_FREE;

    // Sender bookkeeping
    int         items_sent    = 0;
    int         useful_items  = 0;
    int         ticks_sent    = 0;
    int         burst_left    = 1;
    bit         gaps_on       = 1'b1;
    int         settings_used = 0;
    logic [7:0] id_first      = '0;
    logic [7:0] id_second     = '0;

    rc_packet_to_sbus_frame dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .data_byte     (data_byte),
        .byte_position (byte_position),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .sbus_byte     (sbus_byte),
        .frame_end     (frame_end),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    sbus_frame_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .data_byte      (data_byte),
        .byte_position  (byte_position),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .sbus_byte      (sbus_byte),
        .frame_end      (frame_end),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .expected_left  (expected_left),
        .frames_seen    (frames_seen)
    );

    // 10 ns clock
    always #5 clk = ~clk;

    // Cycle count and run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d frame bytes outstanding",
                     cycle_count, expected_left);
            $display("Mismatches found");
            $finish;
        end
    end

    // Receiver: stall pattern in a randomly chosen style (free, choppy or slow)
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            case (sink_mode)
                SINK_CHOPPY: stall_left <= $urandom_range(0, 1);
                SINK_SLOW:   stall_left <= $urandom_range(0, 7);
                default:     stall_left <= 0;
            endcase
        end
        if (cycle_count % 256 == 0)
        begin
            sink_mode <= sink_mode_t'($urandom_range(0, 2));
        end
    end

    function automatic logic [7:0] pick_byte();
        int roll;
        roll = $urandom_range(0, 7);
        if (roll == 0)
        begin
            return 8'h00;
        end
        if (roll == 1)
        begin
            return 8'hFF;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // One input transaction, then maybe a gap once the burst runs out
    task automatic send_item(input logic k, input logic [7:0] d, input logic [4:0] p);
        int gap;
        in_valid      <= 1'b1;
        kind          <= k;
        data_byte     <= d;
        byte_position <= p;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        items_sent++;
        if (k == KIND_TICK)
        begin
            ticks_sent++;
        end
        // spare positions and positions past the end byte are ignored
        if (k == KIND_TICK || !((p >= POS_SPARE_FIRST && p < POS_CH_FIRST) ||
                                p == POS_SPARE_LAST || p > POS_END))
        begin
            useful_items++;
        end
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = gaps_on ? $urandom_range(0, 6) : 0;
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Packet bytes in position order up to last_pos, with stray ticks
    task automatic send_packet(input logic [7:0] len_byte, input logic [7:0] id0,
                               input logic [7:0] id1, input logic [7:0] end_byte,
                               input int last_pos);
        for (int p = 0; p <= last_pos; p++)
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                send_item(KIND_TICK, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)));
            end
            if (5'(p) == POS_LEN)
            begin
                send_item(KIND_BYTE, len_byte, 5'(p));
            end
            else if (5'(p) == POS_ID_FIRST)
            begin
                send_item(KIND_BYTE, id0, 5'(p));
            end
            else if (5'(p) == POS_ID_SECOND)
            begin
                send_item(KIND_BYTE, id1, 5'(p));
            end
            else if (5'(p) == POS_END)
            begin
                send_item(KIND_BYTE, end_byte, 5'(p));
            end
            else if (p >= POS_CH_FIRST && p < POS_CH_FIRST + CHAN_BYTES)
            begin
                send_item(KIND_BYTE, pick_byte(), 5'(p));
            end
            else if ($urandom_range(0, 1) == 1)
            begin
                send_item(KIND_BYTE, 8'($urandom_range(0, 255)), 5'(p));
            end
        end
    endtask

    // Stop sending and wait until every predicted frame byte has come out
    task automatic wait_until_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_left != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Both id registers, back to back on the config channel
    task automatic write_ids(input logic [7:0] first, input logic [7:0] second);
        cfg_valid <= 1'b1;
        cfg_index <= REG_TX_ID_FIRST;
        cfg_data  <= first;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_index <= REG_TX_ID_SECOND;
        cfg_data  <= second;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        id_first  = first;
        id_second = second;
        settings_used++;
    endtask

    initial
    begin
        int         next_setting_at;
        int         choice;
        logic [7:0] id0;
        logic [7:0] id1;
        logic [7:0] len_byte;
        logic [7:0] end_byte;

        next_setting_at = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: ids at reset value zero
        send_item(KIND_TICK, 8'hFF, POS_TOP);                 // tick before any good packet
        send_item(KIND_BYTE, LEN_MARK, POS_LEN);
        send_item(KIND_BYTE, 8'h00, POS_ID_FIRST);
        send_item(KIND_BYTE, 8'h00, POS_ID_SECOND);
        for (int p = POS_SPARE_FIRST; p < POS_CH_FIRST; p++)
        begin
            send_item(KIND_BYTE, 8'hFF, 5'(p));
        end
        for (int i = 0; i < CHAN_BYTES; i++)
        begin
            send_item(KIND_BYTE, EDGE_CHAN[i*8 +: 8], POS_CH_FIRST + 5'(i));
        end
        send_item(KIND_BYTE, 8'hAA, POS_SPARE_LAST);
        send_item(KIND_BYTE, LEN_MARK, POS_BEYOND);           // past the end byte: ignored
        send_item(KIND_BYTE, 8'h00, POS_TOP);
        send_item(KIND_BYTE, 8'h80, POS_END);                 // good packet
        send_item(KIND_BYTE, 8'hFF, POS_END);                 // repeated end byte
        send_item(KIND_BYTE, 8'h7F, POS_END);                 // flag bit clear: dropped
        send_item(KIND_TICK, 8'h00, POS_LEN);                 // resend of last good data

        // Random: all staged bytes are written by now
        while (useful_items < ITEM_TARGET)
        begin
            if (useful_items >= next_setting_at)
            begin
                wait_until_drained();
                case (settings_used)
                    0:       write_ids(8'h00, 8'hFF);
                    1:       write_ids(8'hFF, 8'h00);
                    2:       write_ids(8'hFF, 8'hFF);
                    3:       write_ids(8'h00, 8'h00);
                    default: write_ids(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                endcase
                next_setting_at += SETTING_SPAN;
                gaps_on = ($urandom_range(0, 3) != 0);
            end
            choice = $urandom_range(0, 9);
            if (choice < 7)
            begin
                // well-formed, occasionally with one id bit wrong
                id0 = id_first;
                id1 = id_second;
                if ($urandom_range(0, 7) == 0)
                begin
                    id1 = id1 ^ (8'd1 << $urandom_range(0, 7));
                end
                end_byte = 8'($urandom_range(0, 255)) | (8'd1 << END_OK_BIT);
                send_packet(LEN_MARK, id0, id1, end_byte, POS_END);
            end
            else if (choice < 9)
            begin
                // broken: bad marker, id or end flag, or cut short
                len_byte = ($urandom_range(0, 1) == 1) ? LEN_MARK : pick_byte();
                id0      = ($urandom_range(0, 1) == 1) ? id_first : pick_byte();
                id1      = ($urandom_range(0, 1) == 1) ? id_second : pick_byte();
                end_byte = pick_byte();
                send_packet(len_byte, id0, id1, end_byte, $urandom_range(0, POS_END));
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                begin
                    send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                              5'($urandom_range(0, 31)));
                end
            end
        end

        wait_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d transactions (%0d lost ticks) under %0d transmitter id settings",
                 items_sent, ticks_sent, settings_used);
        $display("Compared %0d SBUS frames byte by byte in %0d cycles",
                 frames_seen, cycle_count);
        if (mismatch_count == 0 && expected_left == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
